@@ rtl/brb_pkg.sv @@
// Shared types and constants for the circular byte FIFO with peek and consume.
// Used by the controller, the datapath and the top level; depends on nothing.

package brb_pkg;

  // Ring geometry and peek limit.
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = 12;
  localparam int CNT_W    = 13;
  localparam int MAX_PEEK = 64;
  localparam int PEEK_W   = 7;

  // Stream beat widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PEEK    = 2'd1,
    OP_CONSUME = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_PEEK = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic peek_start;
    logic peek_emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic peek_go;
    logic peek_last;
  } sts_t;

endpackage

@@ rtl/byte_ring_buffer_peek_consume_top.sv @@
// Top level of the circular byte FIFO with peek and consume.
// Depends on brb_pkg, brb_ctrl, brb_dp (and through it brb_ram).
//
// Usage:
//   Input beats carry an operation in in_tuser: write one byte, peek or
//   consume. A write run announces its length on its first byte; the run is
//   refused whole if the length is zero or exceeds the free space. A peek
//   returns up to min(length, fill, 64) bytes from the read position without
//   removing them; a consume drops min(length, fill) bytes.
//   Every write, consume, refused peek or unknown operation gives one result
//   beat; a successful peek gives one beat per byte, tlast on the final one.
//   Each result carries a status and the fill count after the operation.
// Timing:
//   Single-result beats are accepted one per cycle while the output is free
//   and their result is registered at accept. A peek holds the input until
//   its last byte is emitted: the first read of the byte RAM's registered
//   port is issued at accept, then each emitted byte launches the next read,
//   one byte per cycle. On a receiver stall the output register holds its
//   beat; input waits until that beat is taken or is being taken.
//   Reset (synchronous, active low) empties the ring; RAM contents stay.

module byte_ring_buffer_peek_consume_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brb_pkg::IN_DATA_W-1:0]  in_tdata,   // length[12:0], data_byte[20:13], zero pad
  input  logic [brb_pkg::IN_USER_W-1:0]  in_tuser,   // operation[1:0], run_start[2]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [brb_pkg::OUT_DATA_W-1:0] out_tdata,  // read_byte[7:0], fill_count[20:8], zero pad
  output logic                           out_tlast,  // last_of_run
  output logic [brb_pkg::OUT_USER_W-1:0] out_tuser   // status[1:0]
);

  brb_pkg::cmd_t cmd;
  brb_pkg::sts_t sts;

  // Controller.
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  brb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ rtl/brb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/brb_ctrl.sv @@
// Controller state machine: accepts beats and sequences multi-byte peeks.
// Depends on brb_pkg for the state, command and status types.

module brb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  brb_pkg::sts_t sts,
  output brb_pkg::cmd_t cmd
);

  brb_pkg::state_t state_r;
  brb_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brb_pkg::S_IDLE: begin
        if (in_tvalid && sts.out_free && sts.peek_go) begin
          state_nxt = brb_pkg::S_PEEK;
        end
      end
      brb_pkg::S_PEEK: begin
        if (sts.out_free && sts.peek_last) begin
          state_nxt = brb_pkg::S_IDLE;
        end
      end
      default: state_nxt = brb_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.peek_start = 1'b0;
    cmd.peek_emit  = 1'b0;
    unique case (state_r)
      brb_pkg::S_IDLE: begin
        in_tready      = sts.out_free;
        cmd.accept     = in_tvalid && sts.out_free;
        cmd.peek_start = in_tvalid && sts.out_free && sts.peek_go;
      end
      brb_pkg::S_PEEK: begin
        cmd.peek_emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/brb_dp.sv @@
// Datapath: ring positions, fill count, write-run tracking, byte RAM and
// the output register. Depends on brb_pkg and brb_ram.

module brb_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [brb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [brb_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [brb_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  output logic [brb_pkg::OUT_USER_W-1:0]   out_tuser,
  input  brb_pkg::cmd_t                    cmd,
  output brb_pkg::sts_t                    sts
);

  localparam logic [brb_pkg::CNT_W-1:0] CAP_C =
    brb_pkg::CNT_W'(brb_pkg::CAPACITY);
  localparam logic [brb_pkg::CNT_W-1:0] MAXPK_C =
    brb_pkg::CNT_W'(brb_pkg::MAX_PEEK);

  // Input beat fields.
  brb_pkg::op_t               in_op;
  logic [brb_pkg::CNT_W-1:0]  in_len;
  logic [7:0]                 in_byte;
  logic                       in_start;

  // Ring state.
  logic [brb_pkg::ADDR_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [brb_pkg::ADDR_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [brb_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic [brb_pkg::CNT_W-1:0]  run_rem_r, run_rem_nxt;
  logic                       run_ref_r, run_ref_nxt;

  // Peek sequencing.
  logic [brb_pkg::ADDR_W-1:0] pk_pos_r, pk_pos_nxt;
  logic [brb_pkg::PEEK_W-1:0] pk_cnt_r, pk_cnt_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic                       out_last_r, out_last_nxt;
  brb_pkg::status_t           out_st_r, out_st_nxt;
  logic [brb_pkg::CNT_W-1:0]  out_fill_r, out_fill_nxt;

  // Single-beat op results and helpers.
  logic [brb_pkg::CNT_W-1:0]  free_space;
  logic [brb_pkg::CNT_W-1:0]  take_n;
  logic [brb_pkg::CNT_W-1:0]  peek_n;
  logic                       store_en;
  brb_pkg::status_t           res_st;

  // RAM ports.
  logic                       ram_rd_en;
  logic [brb_pkg::ADDR_W-1:0] ram_rd_addr;
  logic [7:0]                 ram_rd_data;

  assign in_op    = brb_pkg::op_t'(in_tuser[1:0]);
  assign in_start = in_tuser[2];
  assign in_len   = in_tdata[12:0];
  assign in_byte  = in_tdata[20:13];

  assign free_space = CAP_C - held_r;
  assign take_n     = (in_len < held_r) ? in_len : held_r;
  assign peek_n     = (take_n < MAXPK_C) ? take_n : MAXPK_C;

  // Status to the controller.
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.peek_go   = (in_op == brb_pkg::OP_PEEK) && (in_len != '0) && (held_r != '0);
  assign sts.peek_last = (pk_cnt_r == brb_pkg::PEEK_W'(1));

  // Execute a single-result operation on the accepted beat.
  always_comb begin
    rd_pos_nxt  = rd_pos_r;
    wr_pos_nxt  = wr_pos_r;
    held_nxt    = held_r;
    run_rem_nxt = run_rem_r;
    run_ref_nxt = run_ref_r;
    store_en    = 1'b0;
    res_st      = brb_pkg::ST_OK;
    if (cmd.accept && !cmd.peek_start) begin
      unique case (in_op)
        brb_pkg::OP_WRITE: begin
          if (in_start) begin
            run_rem_nxt = '0;
            if (in_len == '0) begin
              run_ref_nxt = 1'b1;
              res_st      = brb_pkg::ST_INVALID;
            end else if (in_len > free_space) begin
              run_ref_nxt = 1'b1;
              res_st      = brb_pkg::ST_NOSPACE;
            end else begin
              run_ref_nxt = 1'b0;
              store_en    = 1'b1;
              run_rem_nxt = in_len - brb_pkg::CNT_W'(1);
            end
          end else if (run_rem_r != '0) begin
            if (held_r < CAP_C) begin
              store_en    = 1'b1;
              run_rem_nxt = run_rem_r - brb_pkg::CNT_W'(1);
            end else begin
              run_rem_nxt = '0;
              res_st      = brb_pkg::ST_NOSPACE;
            end
          end else begin
            res_st = run_ref_r ? brb_pkg::ST_NOSPACE : brb_pkg::ST_INVALID;
          end
        end
        brb_pkg::OP_PEEK: begin
          // Only the no-byte cases reach here.
          res_st = (in_len == '0) ? brb_pkg::ST_INVALID : brb_pkg::ST_EMPTY;
        end
        brb_pkg::OP_CONSUME: begin
          if (in_len == '0) begin
            res_st = brb_pkg::ST_INVALID;
          end else if (held_r == '0) begin
            res_st = brb_pkg::ST_EMPTY;
          end else begin
            rd_pos_nxt = rd_pos_r + take_n[brb_pkg::ADDR_W-1:0];
            held_nxt   = held_r - take_n;
          end
        end
        default: begin
          res_st = brb_pkg::ST_INVALID;
        end
      endcase
      if (store_en) begin
        wr_pos_nxt = wr_pos_r + brb_pkg::ADDR_W'(1);
        held_nxt   = held_r + brb_pkg::CNT_W'(1);
      end
    end
  end

  // Peek sequencing: the first read is issued at accept, each emitted byte
  // issues the read of the following one.
  always_comb begin
    pk_pos_nxt  = pk_pos_r;
    pk_cnt_nxt  = pk_cnt_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rd_pos_r;
    if (cmd.peek_start) begin
      pk_pos_nxt = rd_pos_r;
      pk_cnt_nxt = peek_n[brb_pkg::PEEK_W-1:0];
      ram_rd_en  = 1'b1;
    end else if (cmd.peek_emit) begin
      pk_pos_nxt  = pk_pos_r + brb_pkg::ADDR_W'(1);
      pk_cnt_nxt  = pk_cnt_r - brb_pkg::PEEK_W'(1);
      ram_rd_en   = 1'b1;
      ram_rd_addr = pk_pos_r + brb_pkg::ADDR_W'(1);
    end
  end

  // Output register loading.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    out_fill_nxt  = out_fill_r;
    if (cmd.peek_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = ram_rd_data;
      out_last_nxt  = sts.peek_last;
      out_st_nxt    = brb_pkg::ST_OK;
      out_fill_nxt  = held_r;
    end else if (cmd.accept && !cmd.peek_start) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = '0;
      out_last_nxt  = 1'b1;
      out_st_nxt    = res_st;
      out_fill_nxt  = held_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      held_r      <= '0;
      run_rem_r   <= '0;
      run_ref_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      held_r      <= held_nxt;
      run_rem_r   <= run_rem_nxt;
      run_ref_r   <= run_ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pk_pos_r   <= pk_pos_nxt;
    pk_cnt_r   <= pk_cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
    out_fill_r <= out_fill_nxt;
  end

  // Byte store.
  brb_ram #(
    .WIDTH (8),
    .DEPTH (brb_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (wr_pos_r),
    .wr_data (in_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_fill_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

endmodule

@@ tb/byte_ring_buffer_peek_consume_top_test.sv @@
// Self-checking testbench for byte_ring_buffer_peek_consume_top: write runs, peeks and
// consumes on the input stream, each result beat checked against a mirror of the ring.
// Depends on brb_pkg and the RTL of the top level; reads nothing else.

module byte_ring_buffer_peek_consume_top_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 10;

  // One result beat as the ring owes it.
  typedef struct {
    logic [7:0]                read_byte;
    logic                      last;
    brb_pkg::status_t          status;
    logic [brb_pkg::CNT_W-1:0] fill;
  } reply_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [brb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [brb_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [brb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic [brb_pkg::OUT_USER_W-1:0] out_tuser;

  // Mirror of the ring state.
  logic [7:0] mirror_store [brb_pkg::CAPACITY];
  int         mirror_rd = 0;
  int         mirror_wr = 0;
  int         mirror_held = 0;
  int         mirror_run_left = 0;
  bit         mirror_refused = 1'b0;

  reply_t owed_replies [$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;

  byte_ring_buffer_peek_consume_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // length[12:0], data_byte[20:13], zero pad
    .in_tuser  (in_tuser),   // operation[1:0], run_start[2]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // read_byte[7:0], fill_count[20:8], zero pad
    .out_tlast (out_tlast),  // last_of_run
    .out_tuser (out_tuser)   // status[1:0]
  );

  // Clock with a period of two units.
  initial begin
    forever #1 clk = ~clk;
  end

  // Overall cycle budget.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Queue one owed reply; the fill is the count held after the operation.
  function automatic void owe_reply(logic [7:0] rb, logic last, brb_pkg::status_t st);
    reply_t r;
    r.read_byte = rb;
    r.last      = last;
    r.status    = st;
    r.fill      = mirror_held[brb_pkg::CNT_W-1:0];
    owed_replies.push_back(r);
  endfunction

  function automatic void store_mirror_byte(logic [7:0] db);
    mirror_store[mirror_wr] = db;
    mirror_wr = (mirror_wr + 1) % brb_pkg::CAPACITY;
    mirror_held++;
  endfunction

  // Apply one accepted beat to the mirror and queue the replies it causes.
  function automatic void apply_ring_op(brb_pkg::op_t op, int len, logic [7:0] db, bit start);
    brb_pkg::status_t st;
    int               n;
    int               pos;
    st = brb_pkg::ST_OK;
    case (op)
      brb_pkg::OP_WRITE: begin
        if (start) begin
          mirror_run_left = 0;
          if (len == 0) begin
            mirror_refused = 1'b1;
            st = brb_pkg::ST_INVALID;
          end else if (len > brb_pkg::CAPACITY - mirror_held) begin
            mirror_refused = 1'b1;
            st = brb_pkg::ST_NOSPACE;
          end else begin
            mirror_refused = 1'b0;
            store_mirror_byte(db);
            mirror_run_left = len - 1;
          end
        end else if (mirror_run_left != 0) begin
          if (mirror_held < brb_pkg::CAPACITY) begin
            store_mirror_byte(db);
            mirror_run_left--;
          end else begin
            mirror_run_left = 0;
            st = brb_pkg::ST_NOSPACE;
          end
        end else begin
          st = mirror_refused ? brb_pkg::ST_NOSPACE : brb_pkg::ST_INVALID;
        end
        owe_reply(8'd0, 1'b1, st);
      end
      brb_pkg::OP_PEEK: begin
        if (len == 0) begin
          owe_reply(8'd0, 1'b1, brb_pkg::ST_INVALID);
        end else if (mirror_held == 0) begin
          owe_reply(8'd0, 1'b1, brb_pkg::ST_EMPTY);
        end else begin
          n = (len < mirror_held) ? len : mirror_held;
          if (n > brb_pkg::MAX_PEEK) n = brb_pkg::MAX_PEEK;
          pos = mirror_rd;
          for (int i = 0; i < n; i++) begin
            owe_reply(mirror_store[pos], (i == n - 1), brb_pkg::ST_OK);
            pos = (pos + 1) % brb_pkg::CAPACITY;
          end
        end
      end
      brb_pkg::OP_CONSUME: begin
        if (len == 0) begin
          st = brb_pkg::ST_INVALID;
        end else if (mirror_held == 0) begin
          st = brb_pkg::ST_EMPTY;
        end else begin
          n = (len < mirror_held) ? len : mirror_held;
          mirror_rd = (mirror_rd + n) % brb_pkg::CAPACITY;
          mirror_held -= n;
        end
        owe_reply(8'd0, 1'b1, st);
      end
      default: begin
        owe_reply(8'd0, 1'b1, brb_pkg::ST_INVALID);
      end
    endcase
  endfunction

  // Compare every accepted result beat with the oldest owed reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_replies.size() == 0) begin
        $error("unexpected result beat: read_byte %0d fill_count %0d",
               out_tdata[7:0], out_tdata[20:8]);
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        if (out_tdata[7:0] !== want.read_byte) begin
          $error("read_byte: expected %0d, got %0d", want.read_byte, out_tdata[7:0]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[20:8] !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, out_tdata[20:8]);
          error_count++;
        end
      end
    end
  end

  // Offer one input beat after a random gap and predict it once accepted.
  task automatic send_beat(brb_pkg::op_t op, logic [brb_pkg::CNT_W-1:0] len,
                           logic [7:0] db, bit start);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, db, len};
    in_tuser  <= {start, op};
    do @(posedge clk); while (!in_tready);
    apply_ring_op(op, int'(len), db, start);
  endtask

  // A write run that announces len and sends count bytes of random content.
  task automatic send_write_run(int len, int count);
    send_beat(brb_pkg::OP_WRITE, len[brb_pkg::CNT_W-1:0], 8'($urandom), 1'b1);
    for (int i = 1; i < count; i++) begin
      send_beat(brb_pkg::OP_WRITE, 13'd0, 8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int gap, int stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // Refused runs, stray bytes, an accepted run and a run cut short by a new start.
  task automatic test_write_runs();
    send_beat(brb_pkg::OP_WRITE, 13'd5, 8'h11, 1'b0);
    send_beat(brb_pkg::OP_PEEK, 13'd4, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'd4, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h22, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h33, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'h1FFF, 8'h44, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h55, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd3, 8'h00, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'h1FFF, 8'hFF, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h5A, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'hA5, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd4, 8'h81, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h7E, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'd2, 8'hC3, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h3C, 1'b0);
    wait_drained();
  endtask

  // Peek and consume corner cases plus the unused operation code.
  task automatic test_peek_and_consume();
    send_beat(brb_pkg::OP_PEEK, 13'd0, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_PEEK, 13'h1FFF, 8'hFF, 1'b1);
    send_beat(brb_pkg::OP_PEEK, 13'd2, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'd0, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'd1, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_NONE, 13'h1FFF, 8'hFF, 1'b1);
    send_beat(brb_pkg::OP_NONE, 13'd0, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'h1FFF, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_PEEK, 13'd1, 8'h00, 1'b0);
    wait_drained();
  endtask

  // Run lengths right at the free space and one above it, starting from an empty ring.
  task automatic test_run_length_limits();
    send_beat(brb_pkg::OP_WRITE, 13'(brb_pkg::CAPACITY), 8'h99, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h98, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'(brb_pkg::CAPACITY - 1), 8'h97, 1'b1);
    send_beat(brb_pkg::OP_WRITE, 13'd0, 8'h96, 1'b0);
    send_beat(brb_pkg::OP_WRITE, 13'(brb_pkg::CAPACITY - 2), 8'h95, 1'b1);
    send_beat(brb_pkg::OP_PEEK, 13'd64, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'd2, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_PEEK, 13'd100, 8'h00, 1'b0);
    send_beat(brb_pkg::OP_CONSUME, 13'h1FFF, 8'h00, 1'b0);
    wait_drained();
  endtask

  // Mostly well-formed write runs mixed with peeks, consumes and broken runs.
  task automatic test_random_traffic(int item_goal);
    int sent;
    int pick;
    int run_len;
    int count;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_len = $urandom_range(1, 10);
        count = run_len;
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, run_len);
        else if ($urandom_range(0, 19) == 0) count = run_len + 1;
        send_write_run(run_len, count);
        sent += count;
      end else if (pick < 55) begin
        run_len = ($urandom_range(0, 2) == 0) ? 0 : int'(13'($urandom));
        count = $urandom_range(1, 3);
        send_write_run(run_len, count);
        sent += count;
      end else if (pick < 58) begin
        send_beat(brb_pkg::OP_NONE, 13'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 80) begin
        run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 70) : int'(13'($urandom));
        send_beat(brb_pkg::OP_PEEK, run_len[brb_pkg::CNT_W-1:0], 8'($urandom),
                  1'($urandom));
        sent++;
      end else begin
        run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : int'(13'($urandom));
        send_beat(brb_pkg::OP_CONSUME, run_len[brb_pkg::CNT_W-1:0], 8'($urandom),
                  1'($urandom));
        sent++;
      end
    end
    wait_drained();
  endtask

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_write_runs();
    test_peek_and_consume();
    test_run_length_limits();
    test_random_traffic(35);

    set_idling(57, 0);
    test_random_traffic(35);

    set_idling(0, 57);
    test_random_traffic(35);

    set_idling(20, 20);
    test_random_traffic(35);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && owed_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_ctrl.sv
rtl/brb_dp.sv
rtl/byte_ring_buffer_peek_consume_top.sv
tb/byte_ring_buffer_peek_consume_top_test.sv
